FILE: rtl/wlzx_pkg.sv
package wlzx_pkg;

    localparam int STORE_DEPTH_DEF = 4096;
    localparam int CMP_W           = 17;

    localparam logic [7:0] NEAR_TAG = 8'hA7;
    localparam logic [7:0] FAR_TAG  = 8'hA8;

    typedef enum logic [1:0] {
        FAULT_NONE   = 2'd0,
        FAULT_LENGTH = 2'd1,
        FAULT_REF    = 2'd2
    } t_fault;

    typedef enum logic [2:0] {
        PH_LOW      = 3'd0,
        PH_HIGH     = 3'd1,
        PH_ESCAPE   = 3'd2,
        PH_NEAR_OFS = 3'd3,
        PH_FAR_LO   = 3'd4,
        PH_FAR_HI   = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_RESULT,
        ACT_COPY
    } t_action;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD,
        S_WR,
        S_PUSH
    } t_state;

    typedef struct packed {
        logic accept;
        logic rd;
        logic wr;
        logic push;
    } t_cmd;

    typedef struct packed {
        t_action act;
        logic    copy_last;
        logic    pack_full;
        logic    copy_idle;
        logic    out_free;
    } t_status;

endpackage

FILE: rtl/wlzx_ctrl.sv
module wlzx_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  wlzx_pkg::t_status i_status,
    output wlzx_pkg::t_cmd    o_cmd
);
    import wlzx_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_status.act)
                        ACT_RESULT: n_state = S_PUSH;
                        ACT_COPY:   n_state = S_RD;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_RD: n_state = S_WR;
            S_WR: begin
                if (i_status.copy_last || i_status.pack_full) begin
                    n_state = S_PUSH;
                end else begin
                    n_state = S_RD;
                end
            end
            S_PUSH: begin
                if (i_status.out_free) begin
                    n_state = i_status.copy_idle ? S_IDLE : S_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall   = (r_state != S_IDLE);
        o_cmd.accept = (r_state == S_IDLE) && i_in_valid;
        o_cmd.rd     = (r_state == S_RD);
        o_cmd.wr     = (r_state == S_WR);
        o_cmd.push   = (r_state == S_PUSH) && i_status.out_free;
    end

    ap_push_after_wr_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR) && i_status.copy_last |=> (r_state == S_PUSH))
        else $error("copy end did not lead to push");
    ap_rd_then_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) |=> (r_state == S_WR))
        else $error("read not followed by write");
    ap_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |-> (o_cmd.rd == 1'b0 && o_cmd.wr == 1'b0 && o_cmd.push == 1'b0))
        else $error("accept while busy");

endmodule

FILE: rtl/wlzx_dp.sv
module wlzx_dp #(
    parameter int StoreDepth = wlzx_pkg::STORE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic [13:0]       i_cfg_expanded_bytes,
    input  logic [7:0]        i_data_byte,
    input  logic              i_first_byte,
    input  wlzx_pkg::t_cmd    i_cmd,
    output wlzx_pkg::t_status o_status,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [15:0]       o_word_0,
    output logic [15:0]       o_word_1,
    output logic [15:0]       o_word_2,
    output logic [15:0]       o_word_3,
    output logic [2:0]        o_word_count,
    output logic              o_last_of_run,
    output logic              o_finished,
    output logic [1:0]        o_fault
);
    import wlzx_pkg::*;

    localparam int AW  = $clog2(StoreDepth);
    localparam int PW  = AW + 1;
    localparam int PAD = CMP_W - PW;
    localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(StoreDepth);

    logic [15:0] r_mem [StoreDepth];
    logic [15:0] r_rd_q;

    logic [13:0]   r_exp;
    logic [PW-1:0] r_wp, r_rem;
    t_phase        r_phase;
    logic [7:0]    r_tl, r_th, r_fl;
    logic          r_stopped;
    logic [AW-1:0] r_src;
    logic [7:0]    r_left;
    logic [15:0]   r_pack [4];
    logic [2:0]    r_pack_cnt;
    logic          r_last, r_fin;
    t_fault        r_fault;

    logic          r_out_valid;
    logic [15:0]   r_ow [4];
    logic [2:0]    r_ocnt;
    logic          r_olast, r_ofin;
    t_fault        r_ofault;

    // decode of the byte at the input
    t_action        n_act;
    t_fault         n_fcode;
    logic [15:0]    n_lit;
    logic           n_is_lit;
    logic [AW-1:0]  n_src;
    logic [CMP_W-1:0] words_c, wp_c, rem_c;
    logic [PW-1:0]  words_pw;
    logic           we;
    logic [15:0]    wdata;
    logic           out_free;

    assign out_free = !r_out_valid || !i_out_stall;
    assign wp_c     = {{PAD{1'b0}}, r_wp};
    assign rem_c    = {{PAD{1'b0}}, r_rem};

    always_comb begin
        words_c = {4'b0, r_exp[13:1]};
        if (words_c > DEPTH_C) begin
            words_c = DEPTH_C;
        end
        words_pw = words_c[PW-1:0];
    end

    always_comb begin
        n_act    = ACT_NONE;
        n_fcode  = FAULT_NONE;
        n_lit    = {i_data_byte, r_tl};
        n_is_lit = 1'b0;
        n_src    = r_wp[AW-1:0] - {{(AW-8){1'b0}}, i_data_byte};
        if (i_first_byte) begin
            if (words_pw == '0) begin
                n_act = ACT_RESULT;
            end
        end else if (!r_stopped && r_rem != '0) begin
            unique case (r_phase)
                PH_HIGH: begin
                    if (i_data_byte != NEAR_TAG && i_data_byte != FAR_TAG) begin
                        n_act    = ACT_RESULT;
                        n_is_lit = 1'b1;
                    end
                end
                PH_ESCAPE: begin
                    n_act    = ACT_RESULT;
                    n_is_lit = 1'b1;
                    n_lit    = {r_th, i_data_byte};
                end
                PH_NEAR_OFS, PH_FAR_HI: begin
                    if ({9'b0, r_tl} > rem_c) begin
                        n_act   = ACT_RESULT;
                        n_fcode = FAULT_LENGTH;
                    end else if (r_phase == PH_NEAR_OFS) begin
                        if (i_data_byte == 8'd0 || {9'b0, i_data_byte} > wp_c) begin
                            n_act   = ACT_RESULT;
                            n_fcode = FAULT_REF;
                        end else begin
                            n_act = ACT_COPY;
                        end
                    end else begin
                        n_src = AW'({i_data_byte, r_fl});
                        if ({1'b0, i_data_byte, r_fl} >= wp_c) begin
                            n_act   = ACT_RESULT;
                            n_fcode = FAULT_REF;
                        end else begin
                            n_act = ACT_COPY;
                        end
                    end
                end
                default: n_act = ACT_NONE;
            endcase
        end
    end

    always_comb begin
        o_status.act       = n_act;
        o_status.copy_last = (r_left == 8'd1);
        o_status.pack_full = (r_pack_cnt == 3'd3);
        o_status.copy_idle = (r_left == 8'd0);
        o_status.out_free  = out_free;
    end

    // store write port: literal at accept, copied word in the write step
    assign we    = (i_cmd.accept && n_is_lit) || i_cmd.wr;
    assign wdata = i_cmd.wr ? r_rd_q : n_lit;

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[r_wp[AW-1:0]] <= wdata;
        end
        if (i_cmd.rd) begin
            r_rd_q <= r_mem[r_src];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp       <= '0;
            r_wp        <= '0;
            r_rem       <= '0;
            r_phase     <= PH_LOW;
            r_tl        <= '0;
            r_th        <= '0;
            r_fl        <= '0;
            r_stopped   <= 1'b0;
            r_left      <= '0;
            r_pack_cnt  <= '0;
            r_out_valid <= 1'b0;
            r_last      <= 1'b0;
            r_fin       <= 1'b0;
            r_fault     <= FAULT_NONE;
            r_src       <= '0;
            for (int i = 0; i < 4; i++) begin
                r_pack[i] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                r_exp <= i_cfg_expanded_bytes;
            end
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (i_cmd.accept) begin
                r_fault <= n_fcode;
                r_last  <= 1'b1;
                r_fin   <= 1'b0;
                if (i_first_byte) begin
                    r_wp      <= '0;
                    r_rem     <= words_pw;
                    r_stopped <= 1'b0;
                    r_phase   <= PH_LOW;
                    if (words_pw == '0) begin
                        r_fin <= 1'b1;
                    end else begin
                        r_tl    <= i_data_byte;
                        r_phase <= PH_HIGH;
                    end
                end else if (!r_stopped && r_rem != '0) begin
                    if (n_fcode != FAULT_NONE) begin
                        r_stopped <= 1'b1;
                        r_phase   <= PH_LOW;
                    end else if (n_is_lit) begin
                        r_wp       <= r_wp + 1'b1;
                        r_rem      <= r_rem - 1'b1;
                        r_fin      <= (r_rem == PW'(1));
                        r_pack[0]  <= n_lit;
                        r_pack_cnt <= 3'd1;
                        r_phase    <= PH_LOW;
                        if (r_phase == PH_HIGH) begin
                            r_th <= i_data_byte;
                        end
                    end else if (n_act == ACT_COPY) begin
                        r_src   <= n_src;
                        r_left  <= r_tl;
                        r_phase <= PH_LOW;
                    end else begin
                        unique case (r_phase)
                            PH_LOW: begin
                                r_tl    <= i_data_byte;
                                r_phase <= PH_HIGH;
                            end
                            PH_HIGH: begin
                                r_th <= i_data_byte;
                                if (r_tl == 8'd0) begin
                                    r_phase <= PH_ESCAPE;
                                end else if (i_data_byte == NEAR_TAG) begin
                                    r_phase <= PH_NEAR_OFS;
                                end else begin
                                    r_phase <= PH_FAR_LO;
                                end
                            end
                            PH_FAR_LO: begin
                                r_fl    <= i_data_byte;
                                r_phase <= PH_FAR_HI;
                            end
                            default: r_phase <= PH_LOW;
                        endcase
                    end
                end
            end

            if (i_cmd.wr) begin
                r_wp                   <= r_wp + 1'b1;
                r_rem                  <= r_rem - 1'b1;
                r_src                  <= r_src + 1'b1;
                r_left                 <= r_left - 1'b1;
                r_pack[r_pack_cnt[1:0]] <= r_rd_q;
                r_pack_cnt             <= r_pack_cnt + 3'd1;
                r_last                 <= (r_left == 8'd1);
                r_fin                  <= (r_left == 8'd1) && (r_rem == PW'(1));
                r_fault                <= FAULT_NONE;
            end

            if (i_cmd.push) begin
                r_out_valid <= 1'b1;
                r_pack_cnt  <= '0;
                for (int i = 0; i < 4; i++) begin
                    r_pack[i] <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            for (int i = 0; i < 4; i++) begin
                r_ow[i] <= r_pack[i];
            end
            r_ocnt   <= r_pack_cnt;
            r_olast  <= r_last;
            r_ofin   <= r_fin;
            r_ofault <= r_fault;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_word_0      = r_ow[0];
    assign o_word_1      = r_ow[1];
    assign o_word_2      = r_ow[2];
    assign o_word_3      = r_ow[3];
    assign o_word_count  = r_ocnt;
    assign o_last_of_run = r_olast;
    assign o_finished    = r_ofin;
    assign o_fault       = r_ofault;

    ap_pack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pack_cnt <= 3'd4)
        else $error("pack count overflow");
    ap_wp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wp_c <= DEPTH_C)
        else $error("write position beyond store");
    ap_push_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |=> (r_pack_cnt == 3'd0) && r_out_valid)
        else $error("push did not clear pack");

endmodule

FILE: rtl/word_lz_back_reference_expander_core.sv
// A literal, fault or empty-block result is pushed to the output after its byte
// is accepted; a copy takes a store read, then a write, per word, with a push
// after each group of four words and after the last word. Throughput: one byte
// per cycle for parser bytes; a byte that makes a result or starts a copy stalls
// the input until its last push. Synchronous active-low reset clears the parser,
// positions and output valid; the word store is not cleared.
module word_lz_back_reference_expander_core #(
    parameter int StoreDepth = wlzx_pkg::STORE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [13:0] i_cfg_expanded_bytes,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_word_0,
    output logic [15:0] o_word_1,
    output logic [15:0] o_word_2,
    output logic [15:0] o_word_3,
    output logic [2:0]  o_word_count,
    output logic        o_last_of_run,
    output logic        o_finished,
    output logic [1:0]  o_fault
);
    import wlzx_pkg::*;

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    wlzx_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    wlzx_dp #(
        .StoreDepth (StoreDepth)
    ) u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_valid          (i_cfg_valid),
        .i_cfg_expanded_bytes (i_cfg_expanded_bytes),
        .i_data_byte          (i_data_byte),
        .i_first_byte         (i_first_byte),
        .i_cmd                (cmd),
        .o_status             (status),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_word_0             (o_word_0),
        .o_word_1             (o_word_1),
        .o_word_2             (o_word_2),
        .o_word_3             (o_word_3),
        .o_word_count         (o_word_count),
        .o_last_of_run        (o_last_of_run),
        .o_finished           (o_finished),
        .o_fault              (o_fault)
    );

endmodule
